// ===== sv/temp_sample_averager_unit_assert.svh =====
// Assertion macros shared by the checker of the temperature sample averager.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef TEMP_SAMPLE_AVERAGER_UNIT_ASSERT_SVH
`define TEMP_SAMPLE_AVERAGER_UNIT_ASSERT_SVH

// The property holds in every cycle outside reset.
`define TSA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/tsa_pkg.sv =====
// Types and constants shared by the temperature sample averager modules.
// Depends on nothing else.
package tsa_pkg;

	localparam int TEMP_W = 15;
	localparam int CODE_W = 16;
	localparam int RUN_W  = 8;

	// Conversion: ((code * 17572) >> 16) - 4685 centidegrees.
	localparam logic [14:0] CONV_MULT   = 15'd17572;
	localparam logic [15:0] CONV_OFFSET = 16'd4685;

	// Average reported when a run is aborted: -1.00 degrees.
	localparam logic signed [TEMP_W-1:0] FAIL_AVERAGE = -15'sd100;

	// Register indexes of the configuration port.
	localparam logic REG_ERROR_THRESHOLD = 1'b0;
	localparam logic REG_MAX_ERRORS      = 1'b1;

	typedef struct packed {
		logic signed [TEMP_W-1:0] error_threshold;
		logic [RUN_W-1:0]         max_errors;
	} cfg_t;

	// One classified reading as it waits in the queue.
	typedef struct packed {
		logic signed [TEMP_W-1:0] reading;
		logic                     is_error;
	} entry_t;

	// Handshake between the queue and the back end.
	typedef struct packed {
		logic not_empty;
		logic full;
	} queue_status_t;

endpackage

// ===== sv/tsa_front.sv =====
// Front end: converts a raw sensor code to centidegrees and classifies it
// against the error threshold. Depends on tsa_pkg.
module tsa_front (
	input  logic [tsa_pkg::CODE_W-1:0] raw_code,
	input  tsa_pkg::cfg_t              cfg,
	output tsa_pkg::entry_t            entry
);

	logic [30:0]                       product;
	logic [14:0]                       scaled;
	logic signed [15:0]                centi;

	assign product = 31'(raw_code) * 31'(tsa_pkg::CONV_MULT);
	assign scaled  = product[30:16];
	assign centi   = $signed({1'b0, scaled}) - $signed(tsa_pkg::CONV_OFFSET);

	// A part-select is unsigned, so the reading is re-signed before the compare.
	assign entry.reading  = centi[tsa_pkg::TEMP_W-1:0];
	assign entry.is_error = ($signed(centi[tsa_pkg::TEMP_W-1:0]) >= cfg.error_threshold);

endmodule

// ===== sv/tsa_queue.sv =====
// Four-entry queue between the front and back ends of the averager.
// Depends on tsa_pkg.
module tsa_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  tsa_pkg::entry_t         push_entry,
	input  logic                    pop,
	output tsa_pkg::entry_t         head,
	output tsa_pkg::queue_status_t  status
);

	localparam int DEPTH = 4;

	tsa_pkg::entry_t                mem_q [DEPTH];
	logic [1:0]                     wr_ptr_q;
	logic [1:0]                     rd_ptr_q;
	logic [2:0]                     count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 3'd1;
				2'b01:   count_q <= count_q - 3'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head             = mem_q[rd_ptr_q];
	assign status.not_empty = (count_q != 3'd0);
	assign status.full      = (count_q == 3'(DEPTH));

endmodule

// ===== sv/tsa_back.sv =====
// Back end: accumulates good readings, counts error runs, and computes the
// mean through a reciprocal multiply in a two-stage result pipeline.
// Depends on tsa_pkg.
module tsa_back #(
	parameter int SAMPLE_COUNT = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tsa_pkg::cfg_t                     cfg,
	input  tsa_pkg::entry_t                   head,
	input  tsa_pkg::queue_status_t            status,
	output logic                              pop,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic signed [tsa_pkg::TEMP_W-1:0] average_temp,
	output logic                              success
);

	// Magnitude bound of the sum, and an exact reciprocal for |sum| < 2**MAG_W.
	localparam int MAG_W  = $clog2(SAMPLE_COUNT * 12887 + 1);
	localparam int SUM_W  = MAG_W + 1;
	localparam int CNT_W  = $clog2(SAMPLE_COUNT + 1);
	localparam int SHIFT  = MAG_W + $clog2(SAMPLE_COUNT);
	localparam int PROD_W = MAG_W + SHIFT + 1;
	localparam logic [SHIFT:0] RECIP =
		(SHIFT+1)'(((longint'(1) << SHIFT) + longint'(SAMPLE_COUNT) - 1) / SAMPLE_COUNT);

	logic signed [SUM_W-1:0]     sum_q;
	logic [CNT_W-1:0]            count_q;
	logic [tsa_pkg::RUN_W-1:0]   run_q;

	logic                        valid_s1;
	logic                        ok_s1;
	logic                        neg_s1;
	logic [MAG_W-1:0]            mag_s1;

	logic                        advance;
	logic signed [SUM_W-1:0]     sum_n;
	logic [CNT_W-1:0]            count_n;
	logic [tsa_pkg::RUN_W-1:0]   run_n;
	logic signed [SUM_W-1:0]     sum_abs;
	logic [PROD_W-1:0]           product;
	logic [tsa_pkg::TEMP_W-1:0]  quotient;

	assign advance = !result_valid || !result_stall;
	assign pop     = advance && status.not_empty;

	assign sum_n   = sum_q + SUM_W'(head.reading);
	assign count_n = count_q + CNT_W'(1);
	assign run_n   = (run_q == '1) ? run_q : run_q + tsa_pkg::RUN_W'(1);
	assign sum_abs = sum_n[SUM_W-1] ? -sum_n : sum_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			count_q  <= '0;
			run_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= 1'b0;
			if (pop) begin
				if (head.is_error) begin
					// A limit of zero behaves as one, since run_n is at least one.
					if (run_n >= cfg.max_errors) begin
						valid_s1 <= 1'b1;
						sum_q    <= '0;
						count_q  <= '0;
						run_q    <= '0;
					end else begin
						run_q <= run_n;
					end
				end else if (count_n == CNT_W'(SAMPLE_COUNT)) begin
					valid_s1 <= 1'b1;
					sum_q    <= '0;
					count_q  <= '0;
					run_q    <= '0;
				end else begin
					sum_q   <= sum_n;
					count_q <= count_n;
					run_q   <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pop) begin
			ok_s1  <= !head.is_error;
			neg_s1 <= sum_n[SUM_W-1];
			mag_s1 <= sum_abs[MAG_W-1:0];
		end
	end

	// Truncating division of the magnitude; the sign is applied afterwards,
	// which rounds toward zero.
	assign product  = PROD_W'(mag_s1) * PROD_W'(RECIP);
	assign quotient = product[SHIFT +: tsa_pkg::TEMP_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			success <= ok_s1;
			if (ok_s1) begin
				average_temp <= neg_s1 ? $signed(-quotient) : $signed(quotient);
			end else begin
				average_temp <= tsa_pkg::FAIL_AVERAGE;
			end
		end
	end

endmodule

// ===== sv/temp_sample_averager_unit.sv =====
// Temperature sample averager. A sample transaction is taken in every cycle in
// which the four-entry queue behind the converter has room; sample_stall rises
// only when that queue is full. Each sample leaves the queue in the cycle after
// it is taken while the result side moves; a result passes the s1 stage and the
// result register after the sample that ends a run, and results can follow at
// up to one per cycle while result_stall is low. A run ends with the mean of
// SAMPLE_COUNT good readings or with -100 and success low after max_errors
// rejected readings in a row. Configuration writes are always accepted.
// Depends on tsa_pkg, tsa_front, tsa_queue and tsa_back.
module temp_sample_averager_unit #(
	parameter int SAMPLE_COUNT = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  logic [tsa_pkg::CODE_W-1:0]        raw_code,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic signed [tsa_pkg::TEMP_W-1:0] average_temp,
	output logic                              success,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [tsa_pkg::TEMP_W-1:0]        cfg_data
);

	tsa_pkg::cfg_t           cfg_q;
	tsa_pkg::entry_t         front_entry;
	tsa_pkg::entry_t         head;
	tsa_pkg::queue_status_t  status;
	logic                    push;
	logic                    pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.error_threshold <= 15'sd12800;
			cfg_q.max_errors      <= 8'd5;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tsa_pkg::REG_ERROR_THRESHOLD: cfg_q.error_threshold <= $signed(cfg_data);
				tsa_pkg::REG_MAX_ERRORS:      cfg_q.max_errors <= cfg_data[tsa_pkg::RUN_W-1:0];
				default:                      cfg_q <= cfg_q;
			endcase
		end
	end

	assign sample_stall = status.full;
	assign push         = sample_valid && !status.full;

	tsa_front u_front (
		.raw_code (raw_code),
		.cfg      (cfg_q),
		.entry    (front_entry)
	);

	tsa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (front_entry),
		.pop        (pop),
		.head       (head),
		.status     (status)
	);

	tsa_back #(
		.SAMPLE_COUNT (SAMPLE_COUNT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.status       (status),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.average_temp (average_temp),
		.success      (success)
	);

endmodule

// ===== sv/tsa_checker.sv =====
// Port-level checker for the temperature sample averager, bound to the top.
// Depends on temp_sample_averager_unit_assert.svh.
`include "temp_sample_averager_unit_assert.svh"

module tsa_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic signed [14:0] average_temp,
	input  logic               success
);

	`TSA_ASSERT_NEXT(a_valid_holds, result_valid && result_stall, result_valid, "result dropped while stalled")
	`TSA_ASSERT_NEXT(a_payload_holds, result_valid && result_stall, $stable(average_temp) && $stable(success), "result payload changed while stalled")
	`TSA_ASSERT(a_fail_value, !result_valid || success || (average_temp == -15'sd100), "failure result without the -100 average")
	`TSA_ASSERT(a_avg_range, !result_valid || !success || ((average_temp >= -15'sd4685) && (average_temp <= 15'sd12886)), "average outside the conversion range")

endmodule

bind temp_sample_averager_unit tsa_checker u_tsa_checker (.*);

// ===== test/tb_temp_sample_averager_unit.sv =====
// Self-checking testbench for temp_sample_averager_unit: a directed table, then random phases.
// Each phase uses its own thresholds and error limits, checked against a predictor.
// Depends on tsa_pkg and the temp_sample_averager_unit RTL.
module tb_temp_sample_averager_unit;

	localparam int SAMPLE_COUNT = 8;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_ITEMS = 1100;
	localparam int PHASES       = 6;
	localparam int TAIL_ITEMS   = 100;

	typedef struct packed {
		logic signed [tsa_pkg::TEMP_W-1:0] avg;
		logic                              ok;
	} average_t;

	// One directed row: a sample, or a write of both registers (value holds the threshold).
	typedef struct packed {
		logic                              is_cfg;
		logic [tsa_pkg::CODE_W-1:0]        value;
		logic [tsa_pkg::TEMP_W-1:0]        max_data;
		logic                              typed;
		logic signed [tsa_pkg::TEMP_W-1:0] avg;
		logic                              ok;
	} plan_row_t;

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              sample_valid;
	logic                              sample_stall;
	logic [tsa_pkg::CODE_W-1:0]        raw_code;
	logic                              result_valid;
	logic                              result_stall;
	logic signed [tsa_pkg::TEMP_W-1:0] average_temp;
	logic                              success;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic                              cfg_index;
	logic [tsa_pkg::TEMP_W-1:0]        cfg_data;

	// Predictor copy of the configuration and the run state.
	logic signed [tsa_pkg::TEMP_W-1:0] pred_thr = 15'sd12800;
	logic [tsa_pkg::RUN_W-1:0]         pred_max = 8'd5;
	int                                run_sum = 0;
	int                                run_good = 0;
	int                                run_errors = 0;

	average_t pending_averages[$];
	average_t due;
	int       errors = 0;
	int       cycles = 0;
	int       stall_left = 0;
	logic     stall_on = 1'b1;
	logic     sender_gaps = 1'b1;
	logic     drain = 1'b0;
	logic     calm = 1'b0;

	temp_sample_averager_unit #(
		.SAMPLE_COUNT(SAMPLE_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.raw_code(raw_code),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.average_temp(average_temp),
		.success(success),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Folds one reading into the run; returns 1 when the reading ends the run.
	function automatic logic fold_sample(input logic [tsa_pkg::CODE_W-1:0] code,
			output average_t res);
		int reading;
		int thr;
		reading = ((int'(code) * int'(tsa_pkg::CONV_MULT)) >> 16)
			- int'(tsa_pkg::CONV_OFFSET);
		thr = int'(pred_thr);
		res = '0;
		if (reading >= thr) begin
			if (run_errors < 255)
				run_errors++;
			if (run_errors >= int'(pred_max)) begin
				res.avg = tsa_pkg::FAIL_AVERAGE;
				res.ok = 1'b0;
				run_sum = 0;
				run_good = 0;
				run_errors = 0;
				return 1'b1;
			end
			return 1'b0;
		end
		run_sum += reading;
		run_good++;
		run_errors = 0;
		if (run_good >= SAMPLE_COUNT) begin
			res.avg = tsa_pkg::TEMP_W'(run_sum / SAMPLE_COUNT);
			res.ok = 1'b1;
			run_sum = 0;
			run_good = 0;
			run_errors = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Draws a code that lands below or at/above the current threshold with the given odds.
	function automatic logic [tsa_pkg::CODE_W-1:0] pick_code(input int bad_pct);
		longint span;
		longint tc;
		int roll;
		span = longint'(pred_thr) + longint'(tsa_pkg::CONV_OFFSET);
		if (span <= 0)
			tc = 0;
		else
			tc = (span * 65536 + 17571) / 17572;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return tsa_pkg::CODE_W'($urandom);
		if (roll < 15) begin
			unique case ($urandom_range(0, 3))
				0: return '0;
				1: return '1;
				2: return (tc > 0) ? tsa_pkg::CODE_W'(tc - 1) : '0;
				default: return (tc <= 65535) ? tsa_pkg::CODE_W'(tc) : '1;
			endcase
		end
		if ($urandom_range(0, 99) < bad_pct) begin
			if (tc <= 65535)
				return tsa_pkg::CODE_W'($urandom_range(int'(tc), 65535));
		end else if (tc > 0) begin
			return tsa_pkg::CODE_W'($urandom_range(0, int'(tc) - 1));
		end
		return tsa_pkg::CODE_W'($urandom);
	endfunction

	task automatic send_sample(input logic [tsa_pkg::CODE_W-1:0] code, input logic typed,
			input average_t typed_avg);
		average_t got;
		logic made;
		sample_valid <= 1'b1;
		raw_code <= code;
		do @(posedge clk); while (sample_stall);
		made = fold_sample(code, got);
		if (typed)
			pending_averages.push_back(typed_avg);
		else if (made)
			pending_averages.push_back(got);
	endtask

	task automatic pace(input logic tail);
		if ($urandom_range(0, 49) == 0)
			sender_gaps = !sender_gaps;
		if (!tail && sender_gaps && $urandom_range(0, 3) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// Holds the sender until every expected transaction has arrived and the queue is empty.
	task automatic wait_idle();
		sample_valid <= 1'b0;
		drain <= 1'b1;
		while (pending_averages.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		drain <= 1'b0;
	endtask

	task automatic write_cfg(input logic [tsa_pkg::TEMP_W-1:0] thr,
			input logic [tsa_pkg::TEMP_W-1:0] max_data);
		cfg_valid <= 1'b1;
		cfg_index <= tsa_pkg::REG_ERROR_THRESHOLD;
		cfg_data <= thr;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= tsa_pkg::REG_MAX_ERRORS;
		cfg_data <= max_data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		pred_thr = thr;
		pred_max = max_data[tsa_pkg::RUN_W-1:0];
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (pending_averages.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual average %0d success %0b",
						$time, average_temp, success);
					errors++;
				end else begin
					due = pending_averages.pop_front();
					if (average_temp !== due.avg) begin
						$display("%0t: average_temp expected %0d actual %0d",
							$time, due.avg, average_temp);
						errors++;
					end
					if (success !== due.ok) begin
						$display("%0t: success expected %0b actual %0b", $time, due.ok, success);
						errors++;
					end
				end
			end
			if ($urandom_range(0, 63) == 0)
				stall_on <= !stall_on;
			if (drain || calm) begin
				result_stall <= 1'b0;
				stall_left <= 0;
			end else if (stall_left != 0) begin
				result_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else if (stall_on && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				stall_left <= $urandom_range(0, 6);
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		plan_row_t                         plan[$];
		average_t                          row_avg;
		logic signed [tsa_pkg::TEMP_W-1:0] thr;
		logic [tsa_pkg::TEMP_W-1:0]        max_data;
		logic                              tail;
		int                                bad_pct;
		int                                per_phase;
		int                                sent;

		arst_n = 1'b0;
		sample_valid = 1'b0;
		raw_code = '0;
		cfg_valid = 1'b0;
		cfg_index = tsa_pkg::REG_ERROR_THRESHOLD;
		cfg_data = '0;

		// Defaults after reset: five hottest readings in a row abort the run.
		repeat (4) plan.push_back('{1'b0, 16'hFFFF, 15'd0, 1'b0, 15'sd0, 1'b0});
		plan.push_back('{1'b0, 16'hFFFF, 15'd0, 1'b1, tsa_pkg::FAIL_AVERAGE, 1'b0});
		// Rejected readings in the middle of a run keep the good ones already summed.
		repeat (3) plan.push_back('{1'b0, 16'h0000, 15'd0, 1'b0, 15'sd0, 1'b0});
		repeat (2) plan.push_back('{1'b0, 16'hFFFF, 15'd0, 1'b0, 15'sd0, 1'b0});
		repeat (4) plan.push_back('{1'b0, 16'h0000, 15'd0, 1'b0, 15'sd0, 1'b0});
		plan.push_back('{1'b0, 16'h0000, 15'd0, 1'b1, -15'sd4685, 1'b1});
		// Lowest threshold with a zero limit: every reading aborts at once.
		plan.push_back('{1'b1, 16'h4000, 15'h0000, 1'b0, 15'sd0, 1'b0});
		plan.push_back('{1'b0, 16'h0000, 15'd0, 1'b1, tsa_pkg::FAIL_AVERAGE, 1'b0});
		plan.push_back('{1'b0, 16'hFFFF, 15'd0, 1'b1, tsa_pkg::FAIL_AVERAGE, 1'b0});
		// Highest threshold: a negative sum not divisible by the count truncates toward zero.
		plan.push_back('{1'b1, 16'h3FFF, 15'h7FFF, 1'b0, 15'sd0, 1'b0});
		plan.push_back('{1'b0, 16'h0004, 15'd0, 1'b0, 15'sd0, 1'b0});
		repeat (7) plan.push_back('{1'b0, 16'h0000, 15'd0, 1'b0, 15'sd0, 1'b0});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				wait_idle();
				write_cfg(plan[i].value[tsa_pkg::TEMP_W-1:0], plan[i].max_data);
			end else begin
				row_avg = '{plan[i].avg, plan[i].ok};
				send_sample(plan[i].value, plan[i].typed, row_avg);
				pace(1'b0);
			end
		end

		per_phase = RANDOM_ITEMS / PHASES;
		sent = 0;
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			max_data = tsa_pkg::TEMP_W'($urandom);
			unique case (ph)
				0: begin
					thr = 15'sd12800;
					max_data[tsa_pkg::RUN_W-1:0] = 8'd5;
					bad_pct = 5;
				end
				1: begin
					thr = tsa_pkg::TEMP_W'($urandom_range(0, 12887 + 4685) - 4685);
					max_data[tsa_pkg::RUN_W-1:0] = tsa_pkg::RUN_W'($urandom_range(1, 12));
					bad_pct = 40;
				end
				2: begin
					// Threshold at the coldest reading: every run ends in failure.
					thr = -15'sd4685;
					max_data[tsa_pkg::RUN_W-1:0] = 8'd1;
					bad_pct = 100;
				end
				3: begin
					thr = 15'sd12887;
					max_data[tsa_pkg::RUN_W-1:0] = 8'd255;
					bad_pct = 0;
				end
				4: begin
					thr = tsa_pkg::TEMP_W'($urandom);
					max_data[tsa_pkg::RUN_W-1:0] = tsa_pkg::RUN_W'($urandom_range(0, 255));
					bad_pct = 50;
				end
				default: begin
					thr = tsa_pkg::TEMP_W'($urandom_range(0, 12887 + 4685) - 4685);
					max_data[tsa_pkg::RUN_W-1:0] = tsa_pkg::RUN_W'($urandom_range(1, 8));
					bad_pct = 60;
				end
			endcase
			write_cfg(thr, max_data);
			for (int k = 0; k < per_phase; k++) begin
				tail = (sent >= RANDOM_ITEMS - TAIL_ITEMS);
				calm <= tail;
				send_sample(pick_code(bad_pct), 1'b0, '0);
				sent++;
				pace(tail);
				if (!tail && $urandom_range(0, 199) == 0)
					wait_idle();
			end
		end

		wait_idle();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
